// ===== rtl/pjdq_pkg.sv =====
`timescale 1ns / 1ps

package pjdq_pkg;

    typedef struct packed {
        logic [7:0]  job_id;
        logic [15:0] est_time;
        logic [7:0]  job_priority;
        logic [15:0] arrival_stamp;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED   = 2'd0,
        ST_DISPATCHED = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        POL_ARRIVAL = 2'd0,
        POL_EST     = 2'd1,
        POL_PRIO    = 2'd2
    } t_policy;

    typedef enum logic [1:0] {
        WR_JOB   = 2'd0,
        WR_CARRY = 2'd1,
        WR_RDATA = 2'd2
    } t_wr_src;

    typedef struct packed {
        logic    cap_job;
        logic    rd_en;
        logic    wr_en;
        t_wr_src wr_src;
        logic    carry_ld;
        logic    push;
        logic    pop;
        logic    res_ld;
        t_status res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic swap;
        logic empty;
        logic full;
        logic multi;
    } t_dp_stat;

    function automatic logic [15:0] f_key(input t_job job, input logic [1:0] mode);
        logic [15:0] key;
        case (mode)
            POL_EST:     key = job.est_time;
            POL_PRIO:    key = {8'h00, job.job_priority};
            POL_ARRIVAL: key = job.arrival_stamp;
            default:     key = job.arrival_stamp;
        endcase
        return key;
    endfunction

endpackage

// ===== rtl/pjdq_req_if.sv =====
`timescale 1ns / 1ps

interface pjdq_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  job_id;
    logic [15:0] est_time;
    logic [7:0]  job_priority;
    logic [15:0] arrival_stamp;

    modport source (
        output valid, op, job_id, est_time, job_priority, arrival_stamp,
        input  ready
    );

    modport sink (
        input  valid, op, job_id, est_time, job_priority, arrival_stamp,
        output ready
    );
endinterface

// ===== rtl/pjdq_rsp_if.sv =====
`timescale 1ns / 1ps

interface pjdq_rsp_if #(
    parameter int CNT_W = 5
);
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [7:0]       out_job_id;
    logic [15:0]      out_est_time;
    logic [7:0]       out_priority;
    logic [15:0]      out_arrival;
    logic [CNT_W-1:0] occupancy;

    modport source (
        output valid, status, out_job_id, out_est_time, out_priority, out_arrival,
               occupancy,
        input  ready
    );

    modport sink (
        input  valid, status, out_job_id, out_est_time, out_priority, out_arrival,
               occupancy,
        output ready
    );
endinterface

// ===== rtl/pjdq_cfg_if.sv =====
`timescale 1ns / 1ps

interface pjdq_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] policy_mode;

    modport source (
        output valid, policy_mode,
        input  ready
    );

    modport sink (
        input  valid, policy_mode,
        output ready
    );
endinterface

// ===== rtl/pjdq_ram.sv =====
`timescale 1ns / 1ps

module pjdq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pjdq_datapath.sv =====
`timescale 1ns / 1ps

module pjdq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    localparam int AW         = $clog2(QUEUE_DEPTH),
    localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pjdq_pkg::t_dp_cmd  i_cmd,
    input  logic [CW-1:0]      i_rd_idx,
    input  logic [CW-1:0]      i_wr_idx,
    output pjdq_pkg::t_dp_stat o_stat,
    output logic [CW-1:0]      o_count,
    input  pjdq_pkg::t_job     i_job,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_mode,
    output pjdq_pkg::t_status  o_status,
    output pjdq_pkg::t_job     o_job,
    output logic [CW-1:0]      o_occupancy
);

    import pjdq_pkg::*;

    logic [AW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    logic [1:0]       r_policy;
    t_job             r_job;
    t_job             r_carry;
    t_status          r_res_status;
    t_job             r_res_job;
    logic [CW-1:0]    r_res_occ;

    t_job             w_rdata;
    logic [JOB_W-1:0] w_rdata_raw;
    t_job             w_wdata;
    logic [AW-1:0]    w_raddr;
    logic [AW-1:0]    w_waddr;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [CW-1:0] idx);
        logic [AW+1:0] sum;
        sum = (AW+2)'(head) + (AW+2)'(idx);
        if (sum >= (AW+2)'(QUEUE_DEPTH)) begin
            sum = sum - (AW+2)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign w_raddr = f_slot(r_head, i_rd_idx);
    assign w_waddr = f_slot(r_head, i_wr_idx);
    assign w_rdata = t_job'(w_rdata_raw);

    always_comb begin
        case (i_cmd.wr_src)
            WR_JOB:   w_wdata = r_job;
            WR_CARRY: w_wdata = r_carry;
            WR_RDATA: w_wdata = w_rdata;
            default:  w_wdata = r_carry;
        endcase
    end

    pjdq_ram #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_en),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (i_cmd.rd_en),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata_raw)
    );

    always_comb begin
        o_stat.swap  = f_key(r_carry, r_policy) > f_key(w_rdata, r_policy);
        o_stat.empty = (r_count == '0);
        o_stat.full  = (r_count == CW'(QUEUE_DEPTH));
        o_stat.multi = (r_count > CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_policy <= POL_ARRIVAL;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_mode;
            end
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
                r_head  <= (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_job) begin
            r_job <= i_job;
        end
        if (i_cmd.carry_ld) begin
            r_carry <= w_rdata;
        end
        if (i_cmd.res_ld) begin
            r_res_status <= i_cmd.res_status;
            r_res_job    <= (i_cmd.res_status == ST_DISPATCHED) ? r_carry : '0;
            r_res_occ    <= r_count;
        end
    end

    assign o_count     = r_count;
    assign o_status    = r_res_status;
    assign o_job       = r_res_job;
    assign o_occupancy = r_res_occ;

endmodule

// ===== rtl/pjdq_ctrl.sv =====
`timescale 1ns / 1ps

module pjdq_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  logic               i_op,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output pjdq_pkg::t_dp_cmd  o_cmd,
    output logic [CW-1:0]      o_rd_idx,
    output logic [CW-1:0]      o_wr_idx,
    input  pjdq_pkg::t_dp_stat i_stat,
    input  logic [CW-1:0]      i_count
);

    import pjdq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_RD0,
        S_LD,
        S_RD,
        S_CMP,
        S_END,
        S_POP_RD,
        S_POP,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_idx;
    logic          r_swapped;
    t_status       r_status;
    logic          r_rsp_valid;

    logic          w_accept;
    logic          w_res_free;
    logic [CW-1:0] w_idx_nxt;

    assign w_accept   = i_req_valid && (r_state == S_IDLE);
    assign w_res_free = !r_rsp_valid || i_rsp_ready;
    assign w_idx_nxt  = r_idx + CW'(1);

    always_comb begin
        o_cmd            = '0;
        o_cmd.wr_src     = WR_CARRY;
        o_cmd.res_status = r_status;
        o_rd_idx         = '0;
        o_wr_idx         = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.cap_job = w_accept;
            end
            S_INS: begin
                if (!i_stat.full) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_src = WR_JOB;
                    o_cmd.push   = 1'b1;
                    o_wr_idx     = i_count;
                end
            end
            S_RD0: begin
                o_cmd.rd_en = 1'b1;
            end
            S_LD: begin
                o_cmd.carry_ld = 1'b1;
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                o_rd_idx    = r_idx;
            end
            S_CMP: begin
                o_cmd.wr_en = 1'b1;
                o_wr_idx    = r_idx - CW'(1);
                if (i_stat.swap) begin
                    o_cmd.wr_src = WR_RDATA;
                end else begin
                    o_cmd.carry_ld = 1'b1;
                end
            end
            S_END: begin
                o_cmd.wr_en = 1'b1;
                o_wr_idx    = r_len - CW'(1);
            end
            S_POP_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_POP: begin
                o_cmd.carry_ld = 1'b1;
                o_cmd.pop      = 1'b1;
            end
            S_DONE: begin
                o_cmd.res_ld = w_res_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_idx       <= '0;
            r_swapped   <= 1'b0;
            r_status    <= ST_INSERTED;
            r_rsp_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_res_free) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_op)
                            OP_INSERT: begin
                                r_state <= S_INS;
                            end
                            OP_DISPATCH: begin
                                if (i_stat.empty) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else if (i_stat.multi) begin
                                    r_len   <= i_count;
                                    r_state <= S_RD0;
                                end else begin
                                    r_state <= S_POP_RD;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_INS: begin
                    r_status <= i_stat.full ? ST_FULL : ST_INSERTED;
                    r_state  <= S_DONE;
                end
                S_RD0: begin
                    r_idx     <= CW'(1);
                    r_swapped <= 1'b0;
                    r_state   <= S_LD;
                end
                S_LD: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (i_stat.swap) begin
                        r_swapped <= 1'b1;
                    end
                    r_idx   <= w_idx_nxt;
                    r_state <= (w_idx_nxt == r_len) ? S_END : S_RD;
                end
                S_END: begin
                    r_len   <= r_len - CW'(1);
                    r_state <= (r_swapped && (r_len > CW'(2))) ? S_RD0 : S_POP_RD;
                end
                S_POP_RD: begin
                    r_state <= S_POP;
                end
                S_POP: begin
                    r_status <= ST_DISPATCHED;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (w_res_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

// ===== rtl/policy_job_dispatch_queue_top.sv =====
`timescale 1ns / 1ps

// Bounded job queue with a selectable ordering key (arrival stamp, estimated time or
// priority, from the policy register). One request at a time. A dispatch stable-sorts
// the n waiting jobs in the job RAM with one comparator and a carried element, one RAM
// read and one RAM write per step: bubble passes run over L = n, n-1, ... jobs and stop
// at the first pass without an exchange, then the front job is read and popped. A
// finished result waits in the output register while the next request is accepted.
module policy_job_dispatch_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pjdq_req_if.sink           i_req,
    pjdq_rsp_if.source         o_rsp,
    pjdq_cfg_if.sink           i_cfg
);

    import pjdq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    logic [CW-1:0] w_rd_idx;
    logic [CW-1:0] w_wr_idx;
    logic [CW-1:0] w_count;
    t_job          w_job_in;
    t_job          w_job_out;
    t_status       w_status;
    logic [CW-1:0] w_occupancy;

    assign w_job_in.job_id        = i_req.job_id;
    assign w_job_in.est_time      = i_req.est_time;
    assign w_job_in.job_priority  = i_req.job_priority;
    assign w_job_in.arrival_stamp = i_req.arrival_stamp;

    assign i_cfg.ready = 1'b1;

    pjdq_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req.valid),
        .o_req_ready(i_req.ready),
        .i_op       (i_req.op),
        .o_rsp_valid(o_rsp.valid),
        .i_rsp_ready(o_rsp.ready),
        .o_cmd      (w_cmd),
        .o_rd_idx   (w_rd_idx),
        .o_wr_idx   (w_wr_idx),
        .i_stat     (w_stat),
        .i_count    (w_count)
    );

    pjdq_datapath #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_rd_idx   (w_rd_idx),
        .i_wr_idx   (w_wr_idx),
        .o_stat     (w_stat),
        .o_count    (w_count),
        .i_job      (w_job_in),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_mode (i_cfg.policy_mode),
        .o_status   (w_status),
        .o_job      (w_job_out),
        .o_occupancy(w_occupancy)
    );

    assign o_rsp.status       = w_status;
    assign o_rsp.out_job_id   = w_job_out.job_id;
    assign o_rsp.out_est_time = w_job_out.est_time;
    assign o_rsp.out_priority = w_job_out.job_priority;
    assign o_rsp.out_arrival  = w_job_out.arrival_stamp;
    assign o_rsp.occupancy    = w_occupancy;

endmodule

// ===== rtl/pjdq_checker.sv =====
`timescale 1ns / 1ps

module pjdq_checker #(
    parameter int QUEUE_DEPTH = 16,
    localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  logic          i_rsp_valid,
    input  logic          i_rsp_ready,
    input  logic [1:0]    i_rsp_status,
    input  logic [7:0]    i_rsp_job_id,
    input  logic [15:0]   i_rsp_est_time,
    input  logic [7:0]    i_rsp_priority,
    input  logic [15:0]   i_rsp_arrival,
    input  logic [CW-1:0] i_rsp_occupancy
);

    import pjdq_pkg::*;

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while previous request in progress");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_occupancy)))
        else $error("stalled result changed");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != ST_DISPATCHED)) |->
            (i_rsp_job_id == '0 && i_rsp_est_time == '0 &&
             i_rsp_priority == '0 && i_rsp_arrival == '0))
        else $error("job fields not zero on non-dispatch result");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status == ST_EMPTY)) |-> (i_rsp_occupancy == '0))
        else $error("empty result with nonzero occupancy");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status == ST_FULL)) |->
            (i_rsp_occupancy == CW'(QUEUE_DEPTH)))
        else $error("full result with occupancy below depth");

endmodule

bind policy_job_dispatch_queue_top pjdq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_job_id   (o_rsp.out_job_id),
    .i_rsp_est_time (o_rsp.out_est_time),
    .i_rsp_priority (o_rsp.out_priority),
    .i_rsp_arrival  (o_rsp.out_arrival),
    .i_rsp_occupancy(o_rsp.occupancy)
);

// ===== sim/job_queue_checker.sv =====
`timescale 1ns / 1ps

module job_queue_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pjdq_req_if  i_req,
    pjdq_rsp_if  i_rsp,
    pjdq_cfg_if  i_cfg,
    output int   o_failures,
    output int   o_outstanding
);
    import pjdq_pkg::*;

    typedef struct packed {
        t_status    status;
        t_job       job;
        logic [4:0] occupancy;
    } t_queue_result;

    t_job          job_slots [QUEUE_DEPTH];
    int unsigned   head;
    int unsigned   count;
    logic [1:0]    policy;
    t_queue_result queued_results [$];
    int            failures;
    t_queue_result want;
    t_queue_result got;

    assign o_failures = failures;

    function automatic logic [15:0] sort_key(input t_job job);
        case (policy)
            POL_EST:  return job.est_time;
            POL_PRIO: return {8'h00, job.job_priority};
            default:  return job.arrival_stamp;
        endcase
    endfunction

    function automatic t_queue_result serve_request(input logic op, input t_job job_in);
        t_queue_result res;
        t_job          held;
        int unsigned   a;
        int unsigned   b;
        int unsigned   pass;
        int unsigned   k;
        res = '0;
        if (op == OP_INSERT) begin
            if (count >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                job_slots[(head + count) % QUEUE_DEPTH] = job_in;
                count++;
                res.status = ST_INSERTED;
            end
        end else if (count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            // stable bubble sort over the waiting jobs, front first
            for (pass = 0; pass + 1 < count; pass++) begin
                a = head;
                for (k = 0; k + 1 + pass < count; k++) begin
                    b = (a + 1) % QUEUE_DEPTH;
                    if (sort_key(job_slots[a]) > sort_key(job_slots[b])) begin
                        held = job_slots[a];
                        job_slots[a] = job_slots[b];
                        job_slots[b] = held;
                    end
                    a = b;
                end
            end
            res.job = job_slots[head];
            head = (head + 1) % QUEUE_DEPTH;
            count--;
            res.status = ST_DISPATCHED;
        end
        res.occupancy = 5'(count);
        return res;
    endfunction

    function automatic void report_bad(input string what, input t_queue_result exp_r,
                                       input t_queue_result act_r);
        if (failures < 10) begin
            $display("%0t: %s: expected status=%0d id=%0d est=%0d prio=%0d arr=%0d occ=%0d",
                     $time, what, exp_r.status, exp_r.job.job_id, exp_r.job.est_time,
                     exp_r.job.job_priority, exp_r.job.arrival_stamp, exp_r.occupancy);
            $display("%0t: %s: actual   status=%0d id=%0d est=%0d prio=%0d arr=%0d occ=%0d",
                     $time, what, act_r.status, act_r.job.job_id, act_r.job.est_time,
                     act_r.job.job_priority, act_r.job.arrival_stamp, act_r.occupancy);
        end
        failures++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head = 0;
            count = 0;
            policy = POL_ARRIVAL;
            queued_results.delete();
            failures = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.status = t_status'(i_rsp.status);
                got.job = {i_rsp.out_job_id, i_rsp.out_est_time, i_rsp.out_priority,
                           i_rsp.out_arrival};
                got.occupancy = i_rsp.occupancy;
                if (queued_results.size() == 0) begin
                    report_bad("result with no request waiting", '0, got);
                end else begin
                    want = queued_results.pop_front();
                    if (got.status !== want.status
                            || got.job.job_id !== want.job.job_id
                            || got.job.est_time !== want.job.est_time
                            || got.job.job_priority !== want.job.job_priority
                            || got.job.arrival_stamp !== want.job.arrival_stamp
                            || got.occupancy !== want.occupancy) begin
                        report_bad("wrong result", want, got);
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                policy = i_cfg.policy_mode;
            end
            if (i_req.valid && i_req.ready) begin
                queued_results.push_back(serve_request(i_req.op,
                    {i_req.job_id, i_req.est_time, i_req.job_priority, i_req.arrival_stamp}));
            end
        end
        o_outstanding <= queued_results.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pjdq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int ITEM_TARGET  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 300;

    localparam logic [1:0] POL_ARRIVAL_ALT = 2'd3;

    logic clk;
    logic rst_n;
    int   tx_idle_pct = 18;
    int   rx_idle_pct = 68;
    int   sent;
    int   failures;
    int   outstanding;
    int   quiet_cycles = 0;
    int   phase;
    int   style;
    int   n_ins;
    int   n_dis;

    pjdq_req_if             req_if ();
    pjdq_rsp_if #(.CNT_W(5)) rsp_if ();
    pjdq_cfg_if             cfg_if ();

    policy_job_dispatch_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    job_queue_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_if),
        .i_rsp         (rsp_if),
        .i_cfg         (cfg_if),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("policy_job_dispatch_queue_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_job random_job(input int kind);
        t_job job;
        job.job_id = 8'($urandom);
        case (kind)
            0: begin
                job.est_time      = 16'($urandom);
                job.job_priority  = 8'($urandom);
                job.arrival_stamp = 16'($urandom);
            end
            1: begin
                // narrow keys: force ties
                job.est_time      = 16'($urandom_range(3));
                job.job_priority  = 8'($urandom_range(3));
                job.arrival_stamp = 16'($urandom_range(3));
            end
            default: begin
                job.est_time      = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                job.job_priority  = $urandom_range(1) ? 8'hFF : 8'h00;
                job.arrival_stamp = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
        endcase
        return job;
    endfunction

    task automatic push_request(input logic op, input t_job job);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.op            <= op;
        req_if.job_id        <= job.job_id;
        req_if.est_time      <= job.est_time;
        req_if.job_priority  <= job.job_priority;
        req_if.arrival_stamp <= job.arrival_stamp;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sent++;
    endtask

    task automatic wait_drain;
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_policy(input logic [1:0] mode);
        cfg_if.valid       <= 1'b1;
        cfg_if.policy_mode <= mode;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        rst_n                <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.op            <= OP_INSERT;
        req_if.job_id        <= '0;
        req_if.est_time      <= '0;
        req_if.job_priority  <= '0;
        req_if.arrival_stamp <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.policy_mode   <= POL_ARRIVAL;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_policy(POL_EST);
        push_request(OP_DISPATCH, random_job(0));
        push_request(OP_INSERT, t_job'{8'hFF, 16'hFFFF, 8'h00, 16'h0000});
        push_request(OP_INSERT, t_job'{8'h00, 16'h0000, 8'hFF, 16'hFFFF});
        push_request(OP_DISPATCH, random_job(0));
        for (int i = 0; i < 15; i++) begin
            push_request(OP_INSERT, t_job'{8'(i + 1), 16'(i % 3), 8'(15 - i), 16'(i % 4)});
        end
        push_request(OP_INSERT, random_job(2));
        push_request(OP_DISPATCH, random_job(0));
        push_request(OP_DISPATCH, random_job(0));
        wait_drain;
        write_policy(POL_ARRIVAL_ALT);
        push_request(OP_DISPATCH, random_job(0));
        push_request(OP_DISPATCH, random_job(0));
        wait_drain;
        write_policy(POL_PRIO);
        push_request(OP_DISPATCH, random_job(0));
        push_request(OP_DISPATCH, random_job(0));
        wait_drain;
        write_policy(POL_ARRIVAL);

        sent = 0;
        for (phase = 0; phase < 3; phase++) begin
            // hold until every result is back
            wait_drain;
            tx_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 68 : 0;
            rx_idle_pct <= (phase == 0) ? 68 : (phase == 1) ? 18 : 0;
            while (sent < (phase + 1) * ITEM_TARGET / 3) begin
                if ($urandom_range(3) == 0) begin
                    wait_drain;
                    write_policy(2'($urandom_range(3)));
                end
                style = $urandom_range(2);
                n_ins = $urandom_range(18);
                n_dis = $urandom_range(18);
                repeat (n_ins) begin
                    push_request(($urandom_range(9) == 0) ? OP_DISPATCH : OP_INSERT,
                                 random_job(style));
                end
                repeat (n_dis) begin
                    push_request(($urandom_range(9) == 0) ? OP_INSERT : OP_DISPATCH,
                                 random_job(style));
                end
            end
        end

        wait_drain;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0) begin
            $display("policy_job_dispatch_queue_top: match");
        end else begin
            $display("policy_job_dispatch_queue_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pjdq_pkg.sv
rtl/pjdq_req_if.sv
rtl/pjdq_rsp_if.sv
rtl/pjdq_cfg_if.sv
rtl/pjdq_ram.sv
rtl/pjdq_datapath.sv
rtl/pjdq_ctrl.sv
rtl/policy_job_dispatch_queue_top.sv
rtl/pjdq_checker.sv
sim/job_queue_checker.sv
sim/tb.sv
